// ===== sv/cbrt_pkg.sv =====
// Shared constants for the integer cube root pipeline.
// No dependencies; the interfaces, core and checker use it.

package cbrt_pkg;

   localparam int VALUE_WIDTH = 64;                  // radicand field width
   localparam int ROOT_WIDTH  = 22;                  // root field width
   localparam int INPUT_WIDTH = 64;                  // default significant radicand bits
   localparam int GROUP       = 3;                   // bit positions per root digit
   localparam logic [ROOT_WIDTH-1:0] ROOT_MAX = 22'd2642245;  // cube root of 2^64 - 1

endpackage

// ===== sv/cbrt_if.sv =====
// Valid/ready channels for radicand items and root items.
// Depends on cbrt_pkg for the payload widths.

interface cbrt_req_if;
   logic                             valid;
   logic                             ready;
   logic [cbrt_pkg::VALUE_WIDTH-1:0] value;

   modport source  (output valid, value, input ready);
   modport sink    (input valid, value, output ready);
   modport monitor (input valid, value, ready);
endinterface

interface cbrt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [cbrt_pkg::ROOT_WIDTH-1:0] root;

   modport source  (output valid, root, input ready);
   modport sink    (input valid, root, output ready);
   modport monitor (input valid, root, ready);
endinterface

// ===== sv/cbrt_step.sv =====
// One root digit of the cube root recurrence, split over two register stages.
// Depends on nothing outside itself; instantiated once per digit by the core.

module cbrt_step #(
   parameter int W   = 64,   // significant radicand bits
   parameter int RW  = 22,   // root bits
   parameter int POS = 0     // bit position of this digit
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            vld_in,
   input  logic [W-1:0]    x_in,
   input  logic [RW-1:0]   y_in,
   input  logic [2*RW-1:0] q_in,
   output logic            vld_out,
   output logic [W-1:0]    x_out,
   output logic [RW-1:0]   y_out,
   output logic [2*RW-1:0] q_out
);

   localparam int QW = 2 * RW;
   localparam int TW = QW + 2;
   localparam int CW = (W > TW) ? W : TW;
   localparam logic [W-1:0] LOW_MASK = (W'(1) << POS) - W'(1);

   // trial stage
   logic            a_vld_ff;
   logic [W-1:0]    a_x_ff;
   logic [RW-1:0]   a_y_ff,     a_y_in;
   logic [QW-1:0]   a_q_ff,     a_q_in;
   logic [TW-1:0]   a_trial_ff, a_trial_in;

   // compare/subtract stage
   logic            b_vld_ff;
   logic [W-1:0]    b_x_ff,     b_x_in;
   logic [RW-1:0]   b_y_ff,     b_y_in;
   logic [QW-1:0]   b_q_ff,     b_q_in;

   logic [CW-1:0]   hi;
   logic [CW-1:0]   diff;
   logic            take;

   // double the root; q tracks y*y, so 3y(y+1)+1 = 3q + 3y + 1 without a multiplier
   always_comb begin
      a_y_in     = y_in << 1;
      a_q_in     = q_in << 2;
      a_trial_in = (TW'(a_q_in) << 1) + TW'(a_q_in)
                 + (TW'(a_y_in) << 1) + TW'(a_y_in) + TW'(1);
   end

   always_comb begin
      hi     = CW'(a_x_ff >> POS);
      take   = hi >= CW'(a_trial_ff);
      diff   = hi - CW'(a_trial_ff);
      b_x_in = a_x_ff;
      b_y_in = a_y_ff;
      b_q_in = a_q_ff;
      if (take) begin
         b_x_in = (a_x_ff & LOW_MASK) | (W'(diff) << POS);
         b_y_in = a_y_ff | RW'(1);
         b_q_in = a_q_ff + (QW'(a_y_ff) << 1) + QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= vld_in;
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_x_ff     <= x_in;
         a_y_ff     <= a_y_in;
         a_q_ff     <= a_q_in;
         a_trial_ff <= a_trial_in;
         b_x_ff     <= b_x_in;
         b_y_ff     <= b_y_in;
         b_q_ff     <= b_q_in;
      end
   end

   assign vld_out = b_vld_ff;
   assign x_out   = b_x_ff;
   assign y_out   = b_y_ff;
   assign q_out   = b_q_ff;

endmodule

// ===== sv/integer_cube_root_core.sv =====
// Pipelined floor cube root: one root digit per pair of register stages.
// Depth: 2*steps register stages, steps = (INPUT_WIDTH-1)/3+1 (44 stages at 64 bits).
// Throughput: one item per cycle; the whole pipe holds while the output item waits.
// The last step's registers are the output register.
// Reset (synchronous) clears every stage valid bit; payload registers are not reset.
// Depends on cbrt_pkg, cbrt_if and cbrt_step.

module integer_cube_root_core #(
   parameter int INPUT_WIDTH = cbrt_pkg::INPUT_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   cbrt_req_if.sink          req_ch,
   cbrt_rsp_if.source        rsp_ch
);

   localparam int W  = INPUT_WIDTH;
   localparam int RW = (INPUT_WIDTH - 1) / cbrt_pkg::GROUP + 1;

   logic            vld_s [RW+1];
   logic [W-1:0]    x_s   [RW];
   logic [RW-1:0]   y_s   [RW+1];
   logic [2*RW-1:0] q_s   [RW];
   logic            adv;

   // advance everything unless the output item is stalled
   assign adv          = !vld_s[RW] || rsp_ch.ready;
   assign req_ch.ready = adv;

   // drop radicand bits above INPUT_WIDTH
   assign vld_s[0] = req_ch.valid;
   assign x_s[0]   = req_ch.value[W-1:0];
   assign y_s[0]   = '0;
   assign q_s[0]   = '0;

   for (genvar i = 0; i < RW; i++) begin : g_step
      if (i < RW - 1) begin : g_mid
         cbrt_step #(
            .W   (W),
            .RW  (RW),
            .POS ((RW - 1 - i) * cbrt_pkg::GROUP)
         ) u_step (
            .clock   (clock),
            .reset   (reset),
            .adv     (adv),
            .vld_in  (vld_s[i]),
            .x_in    (x_s[i]),
            .y_in    (y_s[i]),
            .q_in    (q_s[i]),
            .vld_out (vld_s[i+1]),
            .x_out   (x_s[i+1]),
            .y_out   (y_s[i+1]),
            .q_out   (q_s[i+1])
         );
      end else begin : g_last
         cbrt_step #(
            .W   (W),
            .RW  (RW),
            .POS (0)
         ) u_step (
            .clock   (clock),
            .reset   (reset),
            .adv     (adv),
            .vld_in  (vld_s[i]),
            .x_in    (x_s[i]),
            .y_in    (y_s[i]),
            .q_in    (q_s[i]),
            .vld_out (vld_s[i+1]),
            .x_out   (),
            .y_out   (y_s[i+1]),
            .q_out   ()
         );
      end
   end

   assign rsp_ch.valid = vld_s[RW];
   assign rsp_ch.root  = (cbrt_pkg::ROOT_WIDTH)'(y_s[RW]);

endmodule

// ===== sv/cbrt_checker.sv =====
// Port-level checks for integer_cube_root_core, attached by bind.
// Depends on cbrt_pkg for the root bound.

module cbrt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [cbrt_pkg::ROOT_WIDTH-1:0] rsp_root
);

   a_rsp_hold_valid : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_hold_root : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_root))
      else $error("result item changed while stalled");

   a_ready_follows_output : assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready out of step with output stall");

   a_reset_clears : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_root_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_root <= cbrt_pkg::ROOT_MAX)
      else $error("root above cube root of largest radicand");

endmodule

bind integer_cube_root_core cbrt_checker u_cbrt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_root  (rsp_ch.root)
);
